// File: rtl/assert_macros.svh
// assertion helper macros for the frame builder checker
// no dependencies; include with the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// consequent must hold on the edge after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/wsfb_pkg.sv
// shared types and constants for the wheel speed frame builder
// no dependencies
package wsfb_pkg;

	typedef struct packed {
		logic [3:0]        command;
		logic signed [15:0] speed;
		logic signed [15:0] left_speed;
		logic signed [15:0] right_speed;
	} cmd_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} frame_t;

	// one wheel: magnitude and sign flags
	typedef struct packed {
		logic [15:0] mag;
		logic        neg;
		logic        pos;
	} wheel_t;

	// command codes
	localparam logic [3:0] CMD_STOP       = 4'd0;
	localparam logic [3:0] CMD_FWD        = 4'd1;
	localparam logic [3:0] CMD_FWD_RIGHT  = 4'd2;
	localparam logic [3:0] CMD_FWD_LEFT   = 4'd3;
	localparam logic [3:0] CMD_BACK       = 4'd4;
	localparam logic [3:0] CMD_BACK_RIGHT = 4'd5;
	localparam logic [3:0] CMD_BACK_LEFT  = 4'd6;
	localparam logic [3:0] CMD_SPIN_LEFT  = 4'd7;
	localparam logic [3:0] CMD_SPIN_RIGHT = 4'd8;
	localparam logic [3:0] CMD_RAW        = 4'd9;

	// byte positions inside a frame
	localparam logic [3:0] IDX_SYNC    = 4'd0;
	localparam logic [3:0] IDX_ID      = 4'd1;
	localparam logic [3:0] IDX_LMAG_LO = 4'd2;
	localparam logic [3:0] IDX_LMAG_HI = 4'd3;
	localparam logic [3:0] IDX_RMAG_LO = 4'd4;
	localparam logic [3:0] IDX_RMAG_HI = 4'd5;
	localparam logic [3:0] IDX_FLAG    = 4'd6;
	localparam logic [3:0] IDX_CRC_LO  = 4'd7;
	localparam logic [3:0] IDX_CRC_HI  = 4'd8;

	localparam logic [7:0]  SYNC_BYTE   = 8'hFF;
	localparam logic [7:0]  ID_BYTE     = 8'h07;
	localparam logic [7:0]  FLAG_BASE   = 8'hA0;
	localparam logic [7:0]  FLAG_LEFT   = 8'h40;
	localparam logic [7:0]  FLAG_RIGHT  = 8'h10;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;
	// ceil(2^18 / 6): exact quotient for magnitudes below 2^17
	localparam logic [16:0] DIV6_RECIP  = 17'd43691;
	localparam int          DIV6_SHIFT  = 18;

endpackage

// File: rtl/wheel_speed_frame_builder_core.sv
// wheel speed frame builder, top level
// depends on wsfb_pkg
//
// usage
//   cmd channel (cmd_valid / cmd_ready / cmd): one motion command per transfer,
//   carrying the command code, a signed base speed and raw left/right speeds
//   frame channel (frame_valid / frame_ready / frame): nine byte transfers per
//   command, 0xFF, 0x07, left magnitude lo/hi, right magnitude lo/hi, flag,
//   crc16 lo/hi; last_byte marks the crc high byte
//   the command passes through the input register and the frame register
//   before its first frame byte is offered; the byte serializer sends one
//   frame byte per cycle while frame_ready is high, and the next command is
//   taken into the input register while the current frame is still going out
//   the slow wheel of a curved move comes from a 17x17 reciprocal multiply
//   the crc is folded in one byte per cycle as bytes 1 to 6 are sent
//   reset clears all valid flags and the byte counter; no frame is pending
//   when the receiver stalls the current byte holds and, once the input
//   register is full, cmd_ready drops until the frame's last byte is taken
module wheel_speed_frame_builder_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  wsfb_pkg::cmd_t   cmd,
	output logic            frame_valid,
	input  logic            frame_ready,
	output wsfb_pkg::frame_t frame
);
	import wsfb_pkg::*;

	// one crc-16/modbus byte update, eight shift steps
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// input register
	cmd_t        cmd_s1;
	logic        valid_s1;

	// frame register
	logic [15:0] lmag_s2;
	logic [15:0] rmag_s2;
	logic [7:0]  flag_s2;
	logic        valid_s2;

	// serializer
	logic [3:0]  idx_q;
	logic [15:0] crc_q;

	logic        frame_xfer;
	logic        frame_done;
	logic        load_s2;

	// wheel computation
	logic        neg_v, zero_v, pos_v;
	logic [16:0] am;
	logic [33:0] prod;
	logic [15:0] q;
	logic        q_nz;
	wheel_t      fast_p, fast_n, slow_p, slow_n, raw_l, raw_r;
	wheel_t      whl_l, whl_r;
	logic [7:0]  flag_c;
	logic [7:0]  byte_c;

	assign frame_xfer = frame_valid && frame_ready;
	assign frame_done = frame_xfer && (idx_q == IDX_CRC_HI);
	assign load_s2    = valid_s1 && (!valid_s2 || frame_done);
	assign cmd_ready  = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_s1 <= cmd;
		end
	end

	// base speed sign and magnitude, -32768 gives 0x8000
	always_comb begin
		neg_v  = cmd_s1.speed[15];
		zero_v = (cmd_s1.speed == 16'sd0);
		pos_v  = !neg_v && !zero_v;
		am     = neg_v ? (17'd0 - {cmd_s1.speed[15], cmd_s1.speed})
		               : {1'b0, cmd_s1.speed};
		prod   = {17'd0, am} * {17'd0, DIV6_RECIP};
		q      = prod[DIV6_SHIFT +: 16];
		q_nz   = (q != 16'd0);
	end

	// candidate wheels: fast or slow, with speed or with -speed
	always_comb begin
		fast_p = '{mag: am[15:0], neg: neg_v, pos: pos_v};
		fast_n = '{mag: am[15:0], neg: pos_v, pos: neg_v};
		slow_p = '{mag: q, neg: neg_v && q_nz, pos: pos_v && q_nz};
		slow_n = '{mag: q, neg: pos_v && q_nz, pos: neg_v && q_nz};

		raw_l.neg = cmd_s1.left_speed[15];
		raw_l.pos = !cmd_s1.left_speed[15] && (cmd_s1.left_speed != 16'sd0);
		raw_l.mag = raw_l.neg ? (16'd0 - cmd_s1.left_speed) : cmd_s1.left_speed;
		raw_r.neg = cmd_s1.right_speed[15];
		raw_r.pos = !cmd_s1.right_speed[15] && (cmd_s1.right_speed != 16'sd0);
		raw_r.mag = raw_r.neg ? (16'd0 - cmd_s1.right_speed) : cmd_s1.right_speed;
	end

	always_comb begin
		unique case (cmd_s1.command)
			CMD_FWD: begin
				whl_l = fast_p; whl_r = fast_p;
			end
			CMD_FWD_RIGHT: begin
				whl_l = fast_p; whl_r = slow_p;
			end
			CMD_FWD_LEFT: begin
				whl_l = slow_p; whl_r = fast_p;
			end
			CMD_BACK: begin
				whl_l = fast_n; whl_r = fast_n;
			end
			CMD_BACK_RIGHT: begin
				whl_l = fast_n; whl_r = slow_n;
			end
			CMD_BACK_LEFT: begin
				whl_l = slow_n; whl_r = fast_n;
			end
			CMD_SPIN_LEFT: begin
				whl_l = fast_n; whl_r = fast_p;
			end
			CMD_SPIN_RIGHT: begin
				whl_l = fast_p; whl_r = fast_n;
			end
			CMD_RAW: begin
				whl_l = raw_l; whl_r = raw_r;
			end
			default: begin
				// stop and unused codes: both wheels at rest
				whl_l = '0; whl_r = '0;
			end
		endcase
		// left zero counts as forward, right zero does not
		flag_c = FLAG_BASE | (whl_l.neg ? 8'h00 : FLAG_LEFT) | (whl_r.pos ? FLAG_RIGHT : 8'h00);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
		end else if (frame_done) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			lmag_s2 <= whl_l.mag;
			rmag_s2 <= whl_r.mag;
			flag_s2 <= flag_c;
		end
	end

	// byte select for the current position
	always_comb begin
		case (idx_q)
			IDX_SYNC:    byte_c = SYNC_BYTE;
			IDX_ID:      byte_c = ID_BYTE;
			IDX_LMAG_LO: byte_c = lmag_s2[7:0];
			IDX_LMAG_HI: byte_c = lmag_s2[15:8];
			IDX_RMAG_LO: byte_c = rmag_s2[7:0];
			IDX_RMAG_HI: byte_c = rmag_s2[15:8];
			IDX_FLAG:    byte_c = flag_s2;
			IDX_CRC_LO:  byte_c = crc_q[7:0];
			IDX_CRC_HI:  byte_c = crc_q[15:8];
			default:     byte_c = 8'h00;
		endcase
	end

	// position counter and running crc over bytes 1 to 6
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= IDX_SYNC;
			crc_q <= CRC_INIT;
		end else if (frame_xfer) begin
			idx_q <= frame_done ? IDX_SYNC : idx_q + 4'd1;
			if (idx_q == IDX_SYNC) begin
				crc_q <= CRC_INIT;
			end else if (idx_q <= IDX_FLAG) begin
				crc_q <= crc_byte(crc_q, byte_c);
			end
		end
	end

	assign frame_valid      = valid_s2;
	assign frame.frame_byte = byte_c;
	assign frame.last_byte  = (idx_q == IDX_CRC_HI);

endmodule

// File: rtl/wsfb_checker.sv
// port-level checker for the wheel speed frame builder, bound to the top level
// depends on wsfb_pkg and assert_macros.svh
`include "assert_macros.svh"

module wsfb_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             frame_valid,
	input logic             frame_ready,
	input wsfb_pkg::frame_t frame
);
	import wsfb_pkg::*;

	logic [3:0] cnt_q;
	logic       xfer;

	assign xfer = frame_valid && frame_ready;

	// count byte transfers within a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= IDX_SYNC;
		end else if (xfer) begin
			cnt_q <= (cnt_q == IDX_CRC_HI) ? IDX_SYNC : cnt_q + 4'd1;
		end
	end

	`ASSERT_NEXT(a_stall_hold, clk, arst_n, frame_valid && !frame_ready, frame_valid && $stable(frame), "stalled frame byte changed")
	`ASSERT_ALWAYS(a_last_pos, clk, arst_n, !xfer || (frame.last_byte == (cnt_q == IDX_CRC_HI)), "last_byte off the ninth transfer")
	`ASSERT_ALWAYS(a_header, clk, arst_n, !xfer || ((cnt_q != IDX_SYNC || frame.frame_byte == SYNC_BYTE) && (cnt_q != IDX_ID || frame.frame_byte == ID_BYTE)), "frame header bytes wrong")
	`ASSERT_ALWAYS(a_flag_form, clk, arst_n, !xfer || cnt_q != IDX_FLAG || ((frame.frame_byte & 8'hAF) == FLAG_BASE), "flag byte fixed bits wrong")

endmodule

bind wheel_speed_frame_builder_core wsfb_checker u_wsfb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.frame_valid (frame_valid),
	.frame_ready (frame_ready),
	.frame       (frame)
);

// File: sim/tb_top.sv
// testbench for wheel_speed_frame_builder_core: directed table plus random commands,
// each frame byte checked against an in-bench frame predictor with crc16/modbus
// depends on wsfb_pkg and the core rtl
module tb_top;
	import wsfb_pkg::*;

	// codes the core treats as stop
	localparam logic [3:0] CMD_UNUSED_LO = 4'd10;
	localparam logic [3:0] CMD_UNUSED_HI = 4'd15;
	// slow wheel of a curved move is the base speed over this
	localparam int         SLOW_DIV      = 6;
	localparam int         RANDOM_ITEMS  = 205;
	localparam int         HOLD_CYCLES   = 400;
	localparam int         HOLD_AFTER    = 20;
	localparam int         DRAIN_CYCLES  = 20;
	localparam int         CYCLE_LIMIT   = 100000;
	localparam int         REPORT_MAX    = 10;
	localparam logic [4:0] N_DIRECTED    = 5'd25;

	// nine frame bytes, index matches the IDX_* positions
	typedef logic [IDX_CRC_HI:0][7:0] frame_bytes_t;

	// one directed command; typed rows carry the wheel bytes read off by hand
	typedef struct packed {
		cmd_t        c;
		logic        typed;
		logic [15:0] lmag;
		logic [15:0] rmag;
		logic [7:0]  flag;
	} stim_row_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_THIRD, RX_SPARSE} rx_mode_e;

	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		'{'{CMD_STOP,       16'sd1234,   16'sd0,      16'sd0},     1'b1, 16'h0000, 16'h0000, 8'hE0},
		'{'{CMD_FWD,        16'sd32767,  16'sd0,      16'sd0},     1'b1, 16'h7FFF, 16'h7FFF, 8'hF0},
		'{'{CMD_FWD,        -16'sd32767, 16'sd0,      16'sd0},     1'b1, 16'h7FFF, 16'h7FFF, 8'hA0},
		'{'{CMD_FWD,        16'sh8000,   16'sd0,      16'sd0},     1'b1, 16'h8000, 16'h8000, 8'hA0},
		'{'{CMD_BACK,       16'sh8000,   16'sd0,      16'sd0},     1'b1, 16'h8000, 16'h8000, 8'hF0},
		'{'{CMD_FWD,        16'sd0,      16'sd0,      16'sd0},     1'b1, 16'h0000, 16'h0000, 8'hE0},
		'{'{CMD_FWD_RIGHT,  16'sd32767,  16'sd0,      16'sd0},     1'b1, 16'h7FFF, 16'h1555, 8'hF0},
		'{'{CMD_FWD_RIGHT,  16'sd5,      16'sd0,      16'sd0},     1'b1, 16'h0005, 16'h0000, 8'hE0},
		'{'{CMD_FWD_RIGHT,  -16'sd6,     16'sd0,      16'sd0},     1'b1, 16'h0006, 16'h0001, 8'hA0},
		'{'{CMD_FWD_LEFT,   -16'sd32767, 16'sd0,      16'sd0},     1'b1, 16'h1555, 16'h7FFF, 8'hA0},
		'{'{CMD_FWD_LEFT,   16'sd6,      16'sd0,      16'sd0},     1'b1, 16'h0001, 16'h0006, 8'hF0},
		'{'{CMD_BACK_RIGHT, 16'sd100,    16'sd0,      16'sd0},     1'b1, 16'h0064, 16'h0010, 8'hA0},
		'{'{CMD_BACK_LEFT,  -16'sd5,     16'sd0,      16'sd0},     1'b1, 16'h0000, 16'h0005, 8'hF0},
		'{'{CMD_BACK,       16'sd1,      16'sd0,      16'sd0},     1'b1, 16'h0001, 16'h0001, 8'hA0},
		'{'{CMD_SPIN_LEFT,  16'sd300,    16'sd0,      16'sd0},     1'b1, 16'h012C, 16'h012C, 8'hB0},
		'{'{CMD_SPIN_RIGHT, 16'sd300,    16'sd0,      16'sd0},     1'b1, 16'h012C, 16'h012C, 8'hE0},
		'{'{CMD_SPIN_LEFT,  16'sh8000,   16'sd0,      16'sd0},     1'b1, 16'h8000, 16'h8000, 8'hE0},
		'{'{CMD_RAW,        16'sd777,    -16'sd1,     16'sd0},     1'b1, 16'h0001, 16'h0000, 8'hA0},
		'{'{CMD_RAW,        16'sd0,      16'sd0,      16'sd0},     1'b1, 16'h0000, 16'h0000, 8'hE0},
		'{'{CMD_RAW,        16'sd0,      16'sd32767,  16'sh8000},  1'b1, 16'h7FFF, 16'h8000, 8'hE0},
		'{'{CMD_RAW,        16'sd0,      16'sh8000,   16'sd32767}, 1'b1, 16'h8000, 16'h7FFF, 8'hB0},
		'{'{CMD_UNUSED_LO,  16'sd500,    16'sd9,      16'sd9},     1'b1, 16'h0000, 16'h0000, 8'hE0},
		'{'{CMD_UNUSED_HI,  -16'sd1,     -16'sd1,     -16'sd1},    1'b1, 16'h0000, 16'h0000, 8'hE0},
		'{'{CMD_RAW,        16'sh7FFF,   16'sh5A5A,   16'shA5A5},  1'b0, 16'h0000, 16'h0000, 8'h00},
		'{'{CMD_BACK_LEFT,  16'sh7531,   16'shFFFF,   16'sh0000},  1'b0, 16'h0000, 16'h0000, 8'h00}
	};

	logic   clk         = 1'b0;
	logic   arst_n      = 1'b0;
	logic   cmd_valid   = 1'b0;
	logic   frame_ready = 1'b0;
	cmd_t   cmd         = '0;
	logic   cmd_ready;
	logic   frame_valid;
	frame_t frame;

	frame_t frame_bytes_due [$];
	int     fail_count  = 0;
	int     random_sent = 0;
	int     cycle_count = 0;
	int     burst_left  = 0;

	wheel_speed_frame_builder_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame       (frame)
	);

	always #5 clk = ~clk;

	// whole frame from wheel magnitudes and flag; crc16/modbus over id..flag
	function automatic frame_bytes_t frame_from_wheels(input logic [15:0] lmag,
			input logic [15:0] rmag, input logic [7:0] flag);
		frame_bytes_t b;
		logic [15:0]  crc;
		b[IDX_SYNC]    = SYNC_BYTE;
		b[IDX_ID]      = ID_BYTE;
		b[IDX_LMAG_LO] = lmag[7:0];
		b[IDX_LMAG_HI] = lmag[15:8];
		b[IDX_RMAG_LO] = rmag[7:0];
		b[IDX_RMAG_HI] = rmag[15:8];
		b[IDX_FLAG]    = flag;
		crc = CRC_INIT;
		for (logic [3:0] i = IDX_ID; i <= IDX_FLAG; i++) begin
			crc = crc ^ {8'h00, b[i]};
			for (int j = 0; j < 8; j++) begin
				crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
			end
		end
		b[IDX_CRC_LO] = crc[7:0];
		b[IDX_CRC_HI] = crc[15:8];
		return b;
	endfunction

	// wheel speeds for a command, then the frame they make
	function automatic frame_bytes_t predict_frame(input cmd_t c);
		int          v;
		int          l;
		int          r;
		logic [15:0] lmag;
		logic [15:0] rmag;
		logic [7:0]  flag;
		v = int'(c.speed);
		case (c.command)
			CMD_FWD: begin
				l = v;
				r = v;
			end
			CMD_FWD_RIGHT: begin
				l = v;
				r = v / SLOW_DIV;
			end
			CMD_FWD_LEFT: begin
				l = v / SLOW_DIV;
				r = v;
			end
			CMD_BACK: begin
				l = -v;
				r = -v;
			end
			CMD_BACK_RIGHT: begin
				l = -v;
				r = (-v) / SLOW_DIV;
			end
			CMD_BACK_LEFT: begin
				l = (-v) / SLOW_DIV;
				r = -v;
			end
			CMD_SPIN_LEFT: begin
				l = -v;
				r = v;
			end
			CMD_SPIN_RIGHT: begin
				l = v;
				r = -v;
			end
			CMD_RAW: begin
				l = int'(c.left_speed);
				r = int'(c.right_speed);
			end
			default: begin
				l = 0;
				r = 0;
			end
		endcase
		// magnitude of 32768 lands on 0x8000 once cut to 16 bits
		lmag = 16'((l < 0) ? -l : l);
		rmag = 16'((r < 0) ? -r : r);
		flag = FLAG_BASE;
		if (l >= 0) begin
			flag = flag + FLAG_LEFT;
		end
		if (r > 0) begin
			flag = flag + FLAG_RIGHT;
		end
		return frame_from_wheels(lmag, rmag, flag);
	endfunction

	// speeds: full range, near zero, extremes and edge cases of the divide by six
	function automatic logic signed [15:0] pick_speed();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 16'($urandom);
			4, 5:       return 16'($urandom_range(0, 100) - 50);
			6, 7: begin
				case ($urandom_range(0, 5))
					0:       return 16'sh8000;
					1:       return -16'sd32767;
					2:       return 16'sd32767;
					3:       return 16'sd0;
					4:       return -16'sd1;
					default: return 16'($urandom_range(0, 12) - 6);
				endcase
			end
			default:    return 16'($urandom_range(0, 4000) - 2000);
		endcase
	endfunction

	// offer one command, wait for its transfer, queue its nine bytes, then
	// either keep the burst going or drop valid for a random gap
	task automatic offer_command(input cmd_t c, input frame_bytes_t want);
		frame_t fb;
		int     gap;
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (!cmd_ready);
		for (logic [3:0] k = IDX_SYNC; k <= IDX_CRC_HI; k++) begin
			fb.frame_byte = want[k];
			fb.last_byte  = (k == IDX_CRC_HI);
			frame_bytes_due.push_back(fb);
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 15);
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			// now and then a long back-to-back stretch
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 8);
		end
	endtask

	// stimulus: reset, directed table, random commands, drain, verdict
	initial begin
		stim_row_t    row;
		cmd_t         c;
		frame_bytes_t want;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (logic [4:0] i = 5'd0; i < N_DIRECTED; i++) begin
			row  = DIRECTED[i];
			want = row.typed ? frame_from_wheels(row.lmag, row.rmag, row.flag)
				: predict_frame(row.c);
			offer_command(row.c, want);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// mostly real commands, some unused codes
			c.command     = ($urandom_range(0, 9) == 0)
				? 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI))
				: 4'($urandom_range(CMD_STOP, CMD_RAW));
			c.speed       = pick_speed();
			c.left_speed  = pick_speed();
			c.right_speed = pick_speed();
			offer_command(c, predict_frame(c));
			random_sent++;
		end
		cmd_valid <= 1'b0;

		while (frame_bytes_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && frame_bytes_due.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// receiver: random segments of its own stall patterns, plus one long
	// hold-off early in the random part so the core backs up into cmd_ready
	initial begin
		rx_mode_e mode;
		int       seg_left;
		int       phase;
		int       hold_left;
		bit       held;
		mode      = RX_OPEN;
		seg_left  = 0;
		phase     = 0;
		hold_left = 0;
		held      = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && random_sent >= HOLD_AFTER) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				frame_ready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					mode     = rx_mode_e'($urandom_range(0, 3));
					seg_left = $urandom_range(10, 60);
					phase    = 0;
				end
				seg_left--;
				phase++;
				case (mode)
					RX_OPEN:  frame_ready <= 1'b1;
					RX_COIN:  frame_ready <= 1'($urandom_range(0, 1));
					RX_THIRD: frame_ready <= (phase % 3 == 0);
					default:  frame_ready <= ($urandom_range(0, 9) < 3);
				endcase
			end
		end
	end

	// byte checker: every frame transfer against the oldest expected byte
	always @(posedge clk) begin
		frame_t due;
		if (arst_n && frame_valid && frame_ready) begin
			if (frame_bytes_due.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX) begin
					$display("unexpected frame byte: got %h last %b",
						frame.frame_byte, frame.last_byte);
				end
			end else begin
				due = frame_bytes_due.pop_front();
				if (frame.frame_byte !== due.frame_byte
						|| frame.last_byte !== due.last_byte) begin
					fail_count++;
					if (fail_count <= REPORT_MAX) begin
						$display("frame byte mismatch: expected %h last %b, got %h last %b",
							due.frame_byte, due.last_byte, frame.frame_byte, frame.last_byte);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

endmodule

// File: wheel_speed_frame_builder_core.f
+incdir+rtl
rtl/wsfb_pkg.sv
rtl/wheel_speed_frame_builder_core.sv
rtl/wsfb_checker.sv
sim/tb_top.sv
